[hdl/spk32_pkg.sv]
// ----------------------------------------------------------------------------
// Speck 32/64 package
// Controller states, register indexes and fixed constants of the cipher.
// ----------------------------------------------------------------------------
package spk32_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 64;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegKey    = 4'd0;
  localparam logic [CfgIdxW-1:0] RegRounds = 4'd1;

  // Round count used when the rounds register holds zero
  localparam logic [5:0] DefaultRounds = 6'd22;

  // Word and block widths
  localparam int unsigned WordW  = 16;
  localparam int unsigned BlockW = 32;

  // Controller states
  typedef enum logic [1:0] {
    ST_EXPAND,
    ST_IDLE,
    ST_CRYPT
  } spk32_state_e;

endpackage : spk32_pkg

[hdl/speck32_block_cipher_top.sv]
// ----------------------------------------------------------------------------
// Speck 32/64 block cipher
// Encrypts or decrypts one 32-bit block per command with a configurable
// round count. Round keys live in a small synchronous RAM, filled by the
// key schedule after reset and after every key or rounds write.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  --------------------------------
//  config    cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//  command   start_i / busy_o             opcode_i, block_in_i
//  result    done_o (one-cycle strobe)    block_out_o
//
// After an accepted command the first round-key read is launched in the
// accept cycle, then one round per cycle for the active round count (22 by
// default) through the same round logic, reused for every round; the last
// round loads the result register and raises done_o together with it.
// A key or rounds write, and reset, start the key schedule: one round key
// written to the RAM per cycle, one per active round, with busy_o high and
// no command taken. The result beat cannot be held off; the block is idle
// again in the cycle done_o is high and may accept the next command there.
// ----------------------------------------------------------------------------
module speck32_block_cipher_top #(
  parameter int unsigned MAX_ROUNDS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spk32_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [spk32_pkg::CfgDataW-1:0]    cfg_data_i,
  // command
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              opcode_i,
  input  logic [spk32_pkg::BlockW-1:0]      block_in_i,
  // result
  output logic                              done_o,
  output logic [spk32_pkg::BlockW-1:0]      block_out_o
);
  import spk32_pkg::*;

  localparam int unsigned AW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
  localparam int unsigned CW = $clog2(MAX_ROUNDS + 1);
  localparam logic [6:0]  MaxRounds7 = 7'(MAX_ROUNDS);

  // Speck round: a = (a >>> 7) + b ^ k ; b = (b <<< 2) ^ a
  function automatic logic [31:0] fwd_round(input logic [15:0] a,
                                            input logic [15:0] b,
                                            input logic [15:0] k);
    logic [15:0] na;
    logic [15:0] nb;
    na = ({a[6:0], a[15:7]} + b) ^ k;
    nb = {b[13:0], b[15:14]} ^ na;
    return {na, nb};
  endfunction

  // Inverse round: b = (b ^ a) >>> 2 ; a = ((a ^ k) - b) <<< 7
  function automatic logic [31:0] inv_round(input logic [15:0] a,
                                            input logic [15:0] b,
                                            input logic [15:0] k);
    logic [15:0] nb;
    logic [15:0] d;
    nb = {b[1:0] ^ a[1:0], b[15:2] ^ a[15:2]};
    d  = (a ^ k) - nb;
    return {d[8:0], d[15:9], nb};
  endfunction

  spk32_state_e state_q, state_d;

  logic [63:0]       key_q;
  logic [5:0]        rounds_q;
  logic [CW-1:0]     ecnt_q, ecnt_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              done_q, done_d;

  logic [15:0]       a_q, b_q, k_q;
  logic [2:0][15:0]  l_q;
  logic              op_q;
  logic [BlockW-1:0] block_out_q;

  // Round-key RAM
  logic [15:0]       rk_mem [MAX_ROUNDS];
  logic [15:0]       rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [15:0]       mem_wdata;
  logic [AW-1:0]     rd_addr;

  logic              cfg_we;
  logic              cfg_hit;
  logic [6:0]        rnd7;
  logic [CW-1:0]     n_rounds;
  logic [CW-1:0]     last_idx;
  logic [CW-1:0]     dec_next;
  logic [31:0]       ks_step;
  logic [31:0]       rnd_out;

  // Active round count: zero selects the default, saturate at the RAM depth
  always_comb begin
    rnd7 = {1'b0, rounds_q};
    if (rounds_q == '0) begin
      rnd7 = {1'b0, DefaultRounds};
    end
    if (rnd7 > MaxRounds7) begin
      rnd7 = MaxRounds7;
    end
  end
  assign n_rounds = rnd7[CW-1:0];
  assign last_idx = n_rounds - CW'(1);

  assign cfg_we  = cfg_valid_i && cfg_ready_o;
  assign cfg_hit = (cfg_index_i == RegKey) || (cfg_index_i == RegRounds);

  // Key schedule step i = ecnt-1: l word rides in the a slot, k in the b slot
  assign ks_step = fwd_round(l_q[0], k_q, 16'(ecnt_q) - 16'd1);

  // Data round on the key fetched last cycle
  assign rnd_out = op_q ? inv_round(a_q, b_q, rdata_q) : fwd_round(a_q, b_q, rdata_q);

  // Decrypt walks the key RAM downward
  assign dec_next = last_idx - cnt_q - CW'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_EXPAND: begin
        if (ecnt_q == last_idx) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_CRYPT;
        end else if (cfg_we && cfg_hit) begin
          state_d = ST_EXPAND;
        end
      end
      ST_CRYPT: begin
        if (cnt_q == last_idx) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and RAM control
  always_comb begin
    busy_o      = 1'b1;
    cfg_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = ecnt_q[AW-1:0];
    mem_wdata   = ks_step[15:0];
    rd_addr     = '0;
    ecnt_d      = ecnt_q;
    cnt_d       = cnt_q;
    done_d      = 1'b0;
    case (state_q)
      ST_EXPAND: begin
        mem_we = 1'b1;
        if (ecnt_q == '0) begin
          mem_wdata = key_q[15:0];
        end
        ecnt_d = ecnt_q + CW'(1);
      end
      ST_IDLE: begin
        busy_o      = 1'b0;
        cfg_ready_o = !start_i;
        ecnt_d      = '0;
        cnt_d       = '0;
        rd_addr     = opcode_i ? last_idx[AW-1:0] : '0;
      end
      ST_CRYPT: begin
        cnt_d   = cnt_q + CW'(1);
        rd_addr = op_q ? dec_next[AW-1:0] : cnt_d[AW-1:0];
        done_d  = (cnt_q == last_idx);
      end
      default: ;
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_EXPAND;
      ecnt_q   <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      key_q    <= '0;
      rounds_q <= DefaultRounds;
    end else begin
      state_q <= state_d;
      ecnt_q  <= ecnt_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (cfg_we && (cfg_index_i == RegKey)) begin
        key_q <= cfg_data_i;
      end
      if (cfg_we && (cfg_index_i == RegRounds)) begin
        rounds_q <= cfg_data_i[5:0];
      end
    end
  end

  // Datapath and key schedule working words
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      op_q <= opcode_i;
      a_q  <= block_in_i[31:16];
      b_q  <= block_in_i[15:0];
    end else if (state_q == ST_CRYPT) begin
      a_q <= rnd_out[31:16];
      b_q <= rnd_out[15:0];
      if (cnt_q == last_idx) begin
        block_out_q <= rnd_out;
      end
    end
    if (state_q == ST_EXPAND) begin
      if (ecnt_q == '0) begin
        k_q    <= key_q[15:0];
        l_q[0] <= key_q[31:16];
        l_q[1] <= key_q[47:32];
        l_q[2] <= key_q[63:48];
      end else begin
        k_q    <= ks_step[15:0];
        l_q[0] <= l_q[1];
        l_q[1] <= l_q[2];
        l_q[2] <= ks_step[31:16];
      end
    end
  end

  // Round-key RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rk_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= rk_mem[rd_addr];
  end

  assign done_o      = done_q;
  assign block_out_o = block_out_q;

  // Checks
  a_done_after_crypt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_CRYPT))
    else $error("result strobe without a finishing round");

  a_no_write_in_crypt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CRYPT) |-> !mem_we)
    else $error("round-key RAM written while ciphering");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && state_q == ST_CRYPT))
    else $error("accepted command did not start the round loop");

  a_round_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CRYPT || state_q == ST_EXPAND) |-> (cnt_q < n_rounds && ecnt_q < n_rounds))
    else $error("round counter past the active round count");

endmodule : speck32_block_cipher_top
